FILE: sv/pau_pkg.sv
// ----------------------------------------------------------------------------
// Polynomial arithmetic unit package
// Shared codes, controller states and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package pau_pkg;

    // Default number of coefficients held for each operand.
    localparam int MAX_TERMS_DEF = 16;

    // Input word operation codes.
    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_RUN    = 2'd2
    } op_t;

    // Command codes carried by a run word.
    typedef enum logic [2:0] {
        FN_ADD   = 3'd0,
        FN_SUB   = 3'd1,
        FN_MUL   = 3'd2,
        FN_DERIV = 3'd3,
        FN_EVAL  = 3'd4
    } func_t;

    // Source of the next result word.
    typedef enum logic [1:0] {
        OUT_COEF = 2'd0,
        OUT_ZERO = 2'd1,
        OUT_EVAL = 2'd2
    } out_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_SETUP    = 4'd1,
        ST_RD       = 4'd2,
        ST_MUL      = 4'd3,
        ST_ACC      = 4'd4,
        ST_WR       = 4'd5,
        ST_EMIT_RD  = 4'd6,
        ST_EMIT_OUT = 4'd7,
        ST_ZERO_OUT = 4'd8,
        ST_EVAL_OUT = 4'd9
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_a;
        logic     load_b;
        logic     start;
        logic     setup;
        logic     mul_step;
        logic     acc_step;
        logic     inner_next;
        logic     outer_next;
        logic     write;
        logic     emit_start;
        logic     emit_next;
        logic     out_load;
        out_sel_t out_sel;
    } pau_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic inner_last;
        logic outer_last;
        logic is_eval;
        logic cnt_zero;
        logic emit_last;
        logic out_free;
    } pau_stat_t;

endpackage

FILE: sv/pau_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/pau_ctrl.sv
// ----------------------------------------------------------------------------
// Polynomial arithmetic unit controller
// Sequences loads, the per-term compute steps and the emission of results.
// ----------------------------------------------------------------------------
module pau_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [1:0]          op,
    input  logic [2:0]          func,
    input  pau_pkg::pau_stat_t  stat,
    output pau_pkg::pau_cmd_t   cmd
);

    pau_pkg::state_t state_reg;
    pau_pkg::state_t state_next;
    logic            run_ok;

    assign run_ok = (op == pau_pkg::OP_RUN) && (func <= 3'(pau_pkg::FN_EVAL));
    assign cmd_stall = (state_reg != pau_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pau_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pau_pkg::ST_IDLE:
            begin
                if (cmd_valid && run_ok)
                begin
                    state_next = pau_pkg::ST_SETUP;
                end
            end
            pau_pkg::ST_SETUP:
            begin
                if (stat.empty)
                begin
                    state_next = stat.is_eval ? pau_pkg::ST_EVAL_OUT : pau_pkg::ST_ZERO_OUT;
                end
                else
                begin
                    state_next = pau_pkg::ST_RD;
                end
            end
            pau_pkg::ST_RD:
            begin
                state_next = pau_pkg::ST_MUL;
            end
            pau_pkg::ST_MUL:
            begin
                state_next = pau_pkg::ST_ACC;
            end
            pau_pkg::ST_ACC:
            begin
                if (!stat.inner_last)
                begin
                    state_next = pau_pkg::ST_RD;
                end
                else if (stat.is_eval)
                begin
                    state_next = pau_pkg::ST_EVAL_OUT;
                end
                else
                begin
                    state_next = pau_pkg::ST_WR;
                end
            end
            pau_pkg::ST_WR:
            begin
                state_next = stat.outer_last ? pau_pkg::ST_EMIT_RD : pau_pkg::ST_RD;
            end
            pau_pkg::ST_EMIT_RD:
            begin
                state_next = stat.cnt_zero ? pau_pkg::ST_ZERO_OUT : pau_pkg::ST_EMIT_OUT;
            end
            pau_pkg::ST_EMIT_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.emit_last ? pau_pkg::ST_IDLE : pau_pkg::ST_EMIT_RD;
                end
            end
            pau_pkg::ST_ZERO_OUT,
            pau_pkg::ST_EVAL_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = pau_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pau_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.out_sel = pau_pkg::OUT_COEF;
        case (state_reg)
            pau_pkg::ST_IDLE:
            begin
                cmd.load_a = cmd_valid && (op == pau_pkg::OP_LOAD_A);
                cmd.load_b = cmd_valid && (op == pau_pkg::OP_LOAD_B);
                cmd.start  = cmd_valid && run_ok;
            end
            pau_pkg::ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            pau_pkg::ST_MUL:
            begin
                cmd.mul_step = 1'b1;
            end
            pau_pkg::ST_ACC:
            begin
                cmd.acc_step   = 1'b1;
                cmd.inner_next = !stat.inner_last;
            end
            pau_pkg::ST_WR:
            begin
                cmd.write      = 1'b1;
                cmd.emit_start = stat.outer_last;
                cmd.outer_next = !stat.outer_last;
            end
            pau_pkg::ST_EMIT_OUT:
            begin
                cmd.out_load  = stat.out_free;
                cmd.emit_next = stat.out_free && !stat.emit_last;
            end
            pau_pkg::ST_ZERO_OUT:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_sel  = pau_pkg::OUT_ZERO;
            end
            pau_pkg::ST_EVAL_OUT:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_sel  = pau_pkg::OUT_EVAL;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/pau_dp.sv
// ----------------------------------------------------------------------------
// Polynomial arithmetic unit datapath
// Operand and result stores, the shared multiplier, the accumulator, the
// index counters and the output register.
// ----------------------------------------------------------------------------
module pau_dp #(
    parameter int MAX_TERMS = pau_pkg::MAX_TERMS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] coeff,
    input  logic               final_coeff,
    input  logic [2:0]         func,
    input  logic signed [31:0] point,
    input  pau_pkg::pau_cmd_t  cmd,
    output pau_pkg::pau_stat_t stat,
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [31:0] value,
    output logic [4:0]         degree,
    output logic               zero_poly,
    output logic               last
);

    localparam int LW  = $clog2(MAX_TERMS + 1);
    localparam int AW  = $clog2(MAX_TERMS);
    localparam int RD  = 2 * MAX_TERMS - 1;
    localparam int RAW = $clog2(RD);
    localparam int RW  = $clog2(2 * MAX_TERMS);

    logic [LW-1:0]   len_a_reg, len_a_next;
    logic [LW-1:0]   len_b_reg, len_b_next;
    logic [LW-1:0]   load_idx_reg, load_idx_next;
    pau_pkg::func_t  func_reg, func_next;
    logic [31:0]     point_reg;
    logic [RW-1:0]   k_reg, k_next;
    logic [AW-1:0]   i_reg, i_next;
    logic [RW-1:0]   cnt_reg, cnt_next;
    logic [31:0]     acc_reg, acc_next;
    logic [31:0]     prod_reg, prod_next;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     out_value_reg;
    logic [4:0]      out_degree_reg;
    logic            out_zero_reg;
    logic            out_last_reg;

    logic            room;
    logic            we_a, we_b;
    logic [AW-1:0]   addr_a, addr_b;
    logic [31:0]     a_rd, b_rd, r_rd;
    logic [RW-1:0]   la_w, lb_w, n_w, hi_w, k_inc;
    logic [31:0]     a_m, b_m;
    logic [31:0]     mul_x, mul_y, mul_p;
    logic            out_free;

    // Lowest A index that pairs with a valid B index for product term kk.
    function automatic logic [AW-1:0] lo_of(input logic [RW-1:0] kk,
                                            input logic [RW-1:0] lb);
        logic [RW-1:0] kk1;
        kk1 = kk + RW'(1);
        if (kk1 > lb)
        begin
            return AW'(kk1 - lb);
        end
        return '0;
    endfunction

    assign room = load_idx_reg < LW'(MAX_TERMS);
    assign we_a = cmd.load_a && room;
    assign we_b = cmd.load_b && room;

    assign la_w  = RW'(len_a_reg);
    assign lb_w  = RW'(len_b_reg);
    assign k_inc = k_reg + RW'(1);
    assign hi_w  = (k_reg < la_w - RW'(1)) ? k_reg : la_w - RW'(1);

    always_comb
    begin
        case (func_reg)
            pau_pkg::FN_ADD,
            pau_pkg::FN_SUB:
            begin
                n_w    = (la_w > lb_w) ? la_w : lb_w;
                addr_a = AW'(k_reg);
                addr_b = AW'(k_reg);
            end
            pau_pkg::FN_MUL:
            begin
                n_w    = (len_a_reg == '0 || len_b_reg == '0) ? '0 : la_w + lb_w - RW'(1);
                addr_a = i_reg;
                addr_b = AW'(k_reg - RW'(i_reg));
            end
            pau_pkg::FN_DERIV:
            begin
                n_w    = (la_w <= RW'(1)) ? '0 : la_w - RW'(1);
                addr_a = AW'(k_inc);
                addr_b = AW'(k_reg);
            end
            pau_pkg::FN_EVAL:
            begin
                n_w    = la_w;
                addr_a = AW'(la_w - RW'(1) - RW'(i_reg));
                addr_b = AW'(k_reg);
            end
            default:
            begin
                n_w    = '0;
                addr_a = AW'(k_reg);
                addr_b = AW'(k_reg);
            end
        endcase
    end

    pau_ram #(
        .WIDTH (32),
        .DEPTH (MAX_TERMS)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (AW'(load_idx_reg)),
        .wdata (coeff),
        .raddr (addr_a),
        .rdata (a_rd)
    );

    pau_ram #(
        .WIDTH (32),
        .DEPTH (MAX_TERMS)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (AW'(load_idx_reg)),
        .wdata (coeff),
        .raddr (addr_b),
        .rdata (b_rd)
    );

    pau_ram #(
        .WIDTH (32),
        .DEPTH (RD)
    ) u_ram_res (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (RAW'(k_reg)),
        .wdata (acc_reg),
        .raddr (RAW'(k_reg)),
        .rdata (r_rd)
    );

    // Terms past an operand's length count as zero for add and subtract.
    assign a_m = (k_reg < la_w) ? a_rd : '0;
    assign b_m = (k_reg < lb_w) ? b_rd : '0;

    // One shared 32-bit multiplier; only the low word of the product is kept.
    always_comb
    begin
        mul_x = (func_reg == pau_pkg::FN_EVAL) ? acc_reg : a_rd;
        case (func_reg)
            pau_pkg::FN_MUL:   mul_y = b_rd;
            pau_pkg::FN_DERIV: mul_y = 32'(k_inc);
            default:           mul_y = point_reg;
        endcase
    end

    assign mul_p = mul_x * mul_y;

    always_comb
    begin
        case (func_reg)
            pau_pkg::FN_ADD: prod_next = a_m + b_m;
            pau_pkg::FN_SUB: prod_next = a_m - b_m;
            default:         prod_next = mul_p;
        endcase
        if (!cmd.mul_step)
        begin
            prod_next = prod_reg;
        end
    end

    // Evaluation runs Horner's rule, so the accumulator is multiplied by the
    // point and the next lower coefficient is added.
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.setup || cmd.outer_next)
        begin
            acc_next = '0;
        end
        else if (cmd.acc_step)
        begin
            acc_next = (func_reg == pau_pkg::FN_EVAL) ? prod_reg + a_rd : acc_reg + prod_reg;
        end
    end

    always_comb
    begin
        len_a_next    = we_a ? load_idx_reg + LW'(1) : len_a_reg;
        len_b_next    = we_b ? load_idx_reg + LW'(1) : len_b_reg;
        load_idx_next = load_idx_reg;
        if (cmd.load_a || cmd.load_b)
        begin
            if (final_coeff)
            begin
                load_idx_next = '0;
            end
            else if (room)
            begin
                load_idx_next = load_idx_reg + LW'(1);
            end
        end

        func_next = cmd.start ? pau_pkg::func_t'(func) : func_reg;

        k_next = k_reg;
        if (cmd.setup || cmd.emit_start)
        begin
            k_next = '0;
        end
        else if (cmd.outer_next || cmd.emit_next)
        begin
            k_next = k_inc;
        end

        i_next = i_reg;
        if (cmd.setup)
        begin
            i_next = '0;
        end
        else if (cmd.outer_next)
        begin
            i_next = (func_reg == pau_pkg::FN_MUL) ? lo_of(k_inc, lb_w) : '0;
        end
        else if (cmd.inner_next)
        begin
            i_next = i_reg + AW'(1);
        end

        // The count ends just past the highest nonzero coefficient written.
        cnt_next = cnt_reg;
        if (cmd.setup)
        begin
            cnt_next = '0;
        end
        else if (cmd.write && acc_reg != '0)
        begin
            cnt_next = k_inc;
        end
    end

    assign out_free = !out_valid_reg || !res_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            load_idx_reg  <= '0;
            func_reg      <= pau_pkg::FN_ADD;
            k_reg         <= '0;
            i_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_a_reg     <= len_a_next;
            len_b_reg     <= len_b_next;
            load_idx_reg  <= load_idx_next;
            func_reg      <= func_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        if (cmd.start)
        begin
            point_reg <= point;
        end
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                pau_pkg::OUT_COEF:
                begin
                    out_value_reg  <= r_rd;
                    out_degree_reg <= 5'(k_reg);
                    out_zero_reg   <= 1'b0;
                    out_last_reg   <= (k_inc == cnt_reg);
                end
                pau_pkg::OUT_EVAL:
                begin
                    out_value_reg  <= acc_reg;
                    out_degree_reg <= '0;
                    out_zero_reg   <= 1'b0;
                    out_last_reg   <= 1'b1;
                end
                default:
                begin
                    out_value_reg  <= '0;
                    out_degree_reg <= '0;
                    out_zero_reg   <= 1'b1;
                    out_last_reg   <= 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        stat.empty = (n_w == '0);
        stat.outer_last = (k_reg == n_w - RW'(1));
        stat.is_eval = (func_reg == pau_pkg::FN_EVAL);
        stat.cnt_zero = (cnt_reg == '0);
        stat.emit_last = (k_inc == cnt_reg);
        stat.out_free = out_free;
        case (func_reg)
            pau_pkg::FN_MUL:  stat.inner_last = (RW'(i_reg) == hi_w);
            pau_pkg::FN_EVAL: stat.inner_last = (RW'(i_reg) == la_w - RW'(1));
            default:          stat.inner_last = 1'b1;
        endcase
    end

    assign res_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign degree    = out_degree_reg;
    assign zero_poly = out_zero_reg;
    assign last      = out_last_reg;

endmodule

FILE: sv/polynomial_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Polynomial arithmetic unit
// Holds two integer polynomials and computes their sum, difference, product,
// the derivative of A, or A evaluated at a point.
// ----------------------------------------------------------------------------
// A word with op 0 or 1 loads the next coefficient of A or B, lowest degree
// first; final_coeff ends the load, and coefficients beyond MAX_TERMS are
// dropped. A word with op 2 runs the command in func. While a command runs,
// cmd_stall is high and no word is taken. Each result coefficient passes
// once per term through the read, multiply and accumulate steps, the
// multiply using the shared 32-bit multiplier except for add and subtract,
// then through a write step. Evaluation uses Horner's rule and loads its
// value straight into the output register. Other results are then read
// back from the result store, a read step and an output step per word,
// lowest degree first with trailing zero coefficients trimmed; an empty
// result gives one word with zero_poly set.
// The last result word goes into an output register, so the next input word
// is taken while that word still waits on res_stall. All arithmetic wraps at
// 32 bits. Coefficient entries that were never loaded read as anything.
// ----------------------------------------------------------------------------
module polynomial_arithmetic_unit #(
    parameter int MAX_TERMS = pau_pkg::MAX_TERMS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // Input words: coefficient loads and commands.
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [1:0]         op,
    input  logic signed [31:0] coeff,
    input  logic               final_coeff,
    input  logic [2:0]         func,
    input  logic signed [31:0] point,
    // Result words.
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [31:0] value,
    output logic [4:0]         degree,
    output logic               zero_poly,
    output logic               last
);

    pau_pkg::pau_cmd_t  cmd;
    pau_pkg::pau_stat_t stat;

    // The controller only sequences; all storage and arithmetic is below it
    // in the datapath.
    pau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .op        (op),
        .func      (func),
        .stat      (stat),
        .cmd       (cmd)
    );

    pau_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .coeff       (coeff),
        .final_coeff (final_coeff),
        .func        (func),
        .point       (point),
        .cmd         (cmd),
        .stat        (stat),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .value       (value),
        .degree      (degree),
        .zero_poly   (zero_poly),
        .last        (last)
    );

    // A zero result is always a single word holding zero.
    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && zero_poly |-> last && value == 32'sd0 && degree == 5'd0)
        else $error("zero result word is malformed");

    // A valid command holds off further input words on the next cycle.
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && op == pau_pkg::OP_RUN
            && func <= 3'(pau_pkg::FN_EVAL) |=> cmd_stall)
        else $error("command accepted without busy");

    // Trimming leaves a nonzero leading coefficient.
    a_trimmed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last && !zero_poly && degree != 5'd0 |-> value != 32'sd0)
        else $error("trailing zero coefficient emitted");

endmodule

FILE: sim/polynomial_arithmetic_unit_test.sv
// ----------------------------------------------------------------------------
// Polynomial arithmetic unit testbench
// Loads operand polynomials and runs every command against a behavioral
// predictor that keeps its own copy of both operands. Each result word is
// checked field by field against the oldest predicted word, while random
// idle and stall bursts move the handshakes around the block's work.
// ----------------------------------------------------------------------------
module polynomial_arithmetic_unit_test;

    localparam int MAX_TERMS = pau_pkg::MAX_TERMS_DEF;

    // Codes the block must ignore: an unused op and the unused command range.
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [2:0] FN_SPARE_LO = 3'd5;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;

    // The slowest plausible run is a few hundred commands, each a full 16 by
    // 16 product whose 31 result words each wait out the longest stall
    // burst. This limit is several times that.
    localparam int CYCLE_LIMIT = 1_500_000;

    // Cycles allowed after the last result word for anything stray to show up.
    localparam int TAIL_CYCLES = 64;

    typedef struct {
        logic [31:0] value;
        logic [4:0]  degree;
        logic        zero_poly;
        logic        last;
    } term_t;

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    logic [1:0]         op;
    logic signed [31:0] coeff;
    logic               final_coeff;
    logic [2:0]         func;
    logic signed [31:0] point;
    logic               res_valid;
    logic               res_stall;
    logic signed [31:0] value;
    logic [4:0]         degree;
    logic               zero_poly;
    logic               last;

    // Predictor state: the two operands, their lengths and the shared load
    // position, as the block should hold them after every accepted word.
    logic [31:0] poly_a [MAX_TERMS];
    logic [31:0] poly_b [MAX_TERMS];
    int          len_a;
    int          len_b;
    int          load_pos;

    // Which coefficient slots have ever been written. The stimulus uses these
    // so that no command ever reads a slot that holds no defined value.
    bit written_a [MAX_TERMS];
    bit written_b [MAX_TERMS];

    term_t expected_terms [$];
    int    mismatches;
    int    words_sent;
    int    cycle_count;
    bit    bursts_on;

    polynomial_arithmetic_unit #(
        .MAX_TERMS(MAX_TERMS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .op          (op),
        .coeff       (coeff),
        .final_coeff (final_coeff),
        .func        (func),
        .point       (point),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .value       (value),
        .degree      (degree),
        .zero_poly   (zero_poly),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void push_term(input logic [31:0] v, input logic [4:0] d,
                                      input logic z, input logic l);
        term_t t;
        t.value     = v;
        t.degree    = d;
        t.zero_poly = z;
        t.last      = l;
        expected_terms.push_back(t);
    endfunction

    // Updates the operand state for one accepted word and queues the result
    // words that a command produces. Loads and ignored codes queue nothing.
    function automatic void apply_word(input logic [1:0] w_op, input logic [31:0] w_coeff,
                                       input logic w_fin, input logic [2:0] w_func,
                                       input logic [31:0] w_point);
        logic [31:0] terms [2*MAX_TERMS-1];
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] acc;
        logic [31:0] pw;
        int          n;

        if (w_op == pau_pkg::OP_LOAD_A || w_op == pau_pkg::OP_LOAD_B)
        begin
            // Past MAX_TERMS the coefficients are dropped, but the final
            // flag still closes the load.
            if (load_pos < MAX_TERMS)
            begin
                if (w_op == pau_pkg::OP_LOAD_A)
                begin
                    poly_a[load_pos]    = w_coeff;
                    written_a[load_pos] = 1'b1;
                    len_a               = load_pos + 1;
                end
                else
                begin
                    poly_b[load_pos]    = w_coeff;
                    written_b[load_pos] = 1'b1;
                    len_b               = load_pos + 1;
                end
                load_pos++;
            end
            if (w_fin)
                load_pos = 0;
            return;
        end
        if (w_op != pau_pkg::OP_RUN)
            return;

        n = -1;
        case (w_func)
            pau_pkg::FN_ADD, pau_pkg::FN_SUB:
            begin
                n = (len_a > len_b) ? len_a : len_b;
                for (int i = 0; i < n; i++)
                begin
                    a = (i < len_a) ? poly_a[i] : 32'd0;
                    b = (i < len_b) ? poly_b[i] : 32'd0;
                    terms[i] = (w_func == pau_pkg::FN_ADD) ? a + b : a - b;
                end
            end
            pau_pkg::FN_MUL:
            begin
                // A product with an empty operand is the zero polynomial.
                n = (len_a == 0 || len_b == 0) ? 0 : len_a + len_b - 1;
                for (int i = 0; i < n; i++)
                    terms[i] = 32'd0;
                for (int i = 0; i < len_a && n > 0; i++)
                    for (int j = 0; j < len_b; j++)
                        terms[i + j] = terms[i + j] + poly_a[i] * poly_b[j];
            end
            pau_pkg::FN_DERIV:
            begin
                n = (len_a <= 1) ? 0 : len_a - 1;
                for (int i = 1; i < len_a; i++)
                    terms[i - 1] = poly_a[i] * 32'(i);
            end
            pau_pkg::FN_EVAL:
            begin
                acc = 32'd0;
                pw  = 32'd1;
                for (int i = 0; i < len_a; i++)
                begin
                    acc = acc + poly_a[i] * pw;
                    pw  = pw * w_point;
                end
                push_term(acc, 5'd0, 1'b0, 1'b1);
            end
            default:
                ;
        endcase

        if (n < 0)
            return;
        // Trailing zero coefficients are trimmed; nothing left means a
        // single word flagged as the zero polynomial.
        while (n > 0 && terms[n - 1] == 32'd0)
            n--;
        if (n == 0)
            push_term(32'd0, 5'd0, 1'b1, 1'b1);
        for (int k = 0; k < n; k++)
            push_term(terms[k], 5'(k), 1'b0, k == n - 1);
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    // Every accepted result word is held up against the oldest prediction.
    always @(posedge clk)
    begin
        term_t want;

        if (rst_n && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (expected_terms.size() == 0)
            begin
                $error("result word with nothing expected: value %0d degree %0d",
                       value, degree);
                mismatches++;
            end
            else
            begin
                want = expected_terms.pop_front();
                if (value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", $signed(want.value), value);
                    mismatches++;
                end
                if (degree !== want.degree)
                begin
                    $error("degree: expected %0d, got %0d", want.degree, degree);
                    mismatches++;
                end
                if (zero_poly !== want.zero_poly)
                begin
                    $error("zero_poly: expected %0b, got %0b", want.zero_poly, zero_poly);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    // The receiver stalls in random bursts; between bursts it takes words
    // freely, so stall-free stretches of varying length come up as well.
    initial
    begin
        res_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (bursts_on && $urandom_range(0, 3) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[polynomial_arithmetic_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mixes full-range values with small ones, zeros and the 32-bit extremes,
    // so that trimming, cancellation and wrapping all come up often.
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            3, 4:    return 32'(int'($urandom_range(0, 16)) - 8);
            5:       return 32'd0;
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Mostly short polynomials; now and then a long one, and rarely a load
    // that runs past MAX_TERMS.
    function automatic int pick_length();
        case ($urandom_range(0, 9))
            7, 8:    return $urandom_range(6, MAX_TERMS);
            9:       return $urandom_range(MAX_TERMS, MAX_TERMS + 3);
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    // A word may write slot idx of an operand only when every slot below it
    // already holds a defined value, since the new length covers them all.
    function automatic bit may_write(input logic [1:0] sel, input int idx);
        for (int i = 0; i < idx && i < MAX_TERMS; i++)
            if (!(sel == pau_pkg::OP_LOAD_A ? written_a[i] : written_b[i]))
                return 1'b0;
        return 1'b1;
    endfunction

    // Presents one word, waits for it to be taken and hands it to the
    // predictor. The valid stays high into the next call unless that call
    // opens with an idle burst.
    task automatic send_word(input logic [1:0] w_op, input logic [31:0] w_coeff,
                             input logic w_fin, input logic [2:0] w_func,
                             input logic [31:0] w_point);
        int gap;

        if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid   <= 1'b1;
        op          <= w_op;
        coeff       <= w_coeff;
        final_coeff <= w_fin;
        func        <= w_func;
        point       <= w_point;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        apply_word(w_op, w_coeff, w_fin, w_func, w_point);
        if (w_op != OP_UNUSED && !(w_op == pau_pkg::OP_RUN && w_func > pau_pkg::FN_EVAL))
            words_sent++;
    endtask

    // Load and command words; the fields that the word does not use carry
    // random values so that they toggle too.
    task automatic load_coeff(input logic [1:0] sel, input logic [31:0] c, input logic fin);
        send_word(sel, c, fin, 3'($urandom), $urandom);
    endtask

    task automatic run_cmd(input logic [2:0] f, input logic [31:0] x);
        send_word(pau_pkg::OP_RUN, $urandom, 1'($urandom), f, x);
    endtask

    // Loads len coefficients starting with operand sel. With mixing on, the
    // load sometimes hops to the other operand at the same position.
    task automatic load_poly(input logic [1:0] sel, input int len, input bit mix);
        logic [1:0] cur;
        logic [1:0] other;

        cur = sel;
        for (int idx = 0; idx < len; idx++)
        begin
            other = (cur == pau_pkg::OP_LOAD_A) ? pau_pkg::OP_LOAD_B : pau_pkg::OP_LOAD_A;
            if (mix && idx > 0 && $urandom_range(0, 4) == 0 && may_write(other, idx))
                cur = other;
            load_coeff(cur, rand_value(), idx == len - 1);
        end
    endtask

    // Holds the sender off until every predicted result word has arrived.
    task automatic wait_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_terms.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Right after reset both operands are empty: sums, products and the
    // derivative give the zero polynomial and evaluation gives zero.
    task automatic test_empty_operands();
        run_cmd(pau_pkg::FN_ADD, 32'd0);
        run_cmd(pau_pkg::FN_SUB, 32'd0);
        run_cmd(pau_pkg::FN_MUL, 32'd0);
        run_cmd(pau_pkg::FN_DERIV, 32'd0);
        run_cmd(pau_pkg::FN_EVAL, 32'd5);
    endtask

    // Coefficients and points at the 32-bit extremes, so that subtraction,
    // the product and evaluation wrap.
    task automatic test_extreme_values();
        load_coeff(pau_pkg::OP_LOAD_A, 32'h7FFF_FFFF, 1'b0);
        load_coeff(pau_pkg::OP_LOAD_A, 32'h8000_0000, 1'b0);
        load_coeff(pau_pkg::OP_LOAD_A, 32'hFFFF_FFFF, 1'b1);
        load_coeff(pau_pkg::OP_LOAD_B, 32'h8000_0000, 1'b0);
        load_coeff(pau_pkg::OP_LOAD_B, 32'h7FFF_FFFF, 1'b1);
        run_cmd(pau_pkg::FN_ADD, 32'd0);
        run_cmd(pau_pkg::FN_SUB, 32'hFFFF_FFFF);
        run_cmd(pau_pkg::FN_MUL, 32'd0);
        run_cmd(pau_pkg::FN_DERIV, 32'd0);
        run_cmd(pau_pkg::FN_EVAL, 32'h8000_0000);
        run_cmd(pau_pkg::FN_EVAL, 32'hFFFF_FFFF);
    endtask

    // A load that starts on A and finishes on B at the next position leaves
    // A constant, so its derivative is the zero polynomial. Unused op and
    // command codes in between must change nothing.
    task automatic test_mixed_load();
        load_coeff(pau_pkg::OP_LOAD_A, 32'd9, 1'b0);
        load_coeff(pau_pkg::OP_LOAD_B, 32'hFFFF_FFFD, 1'b1);
        run_cmd(pau_pkg::FN_DERIV, 32'd0);
        run_cmd(pau_pkg::FN_MUL, 32'd0);
        send_word(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, FN_SPARE_HI, 32'hFFFF_FFFF);
        run_cmd(FN_SPARE_LO, 32'd0);
        run_cmd(FN_SPARE_HI, 32'hFFFF_FFFF);
        run_cmd(pau_pkg::FN_EVAL, 32'd2);
    endtask

    // Loads that run past MAX_TERMS are cut to MAX_TERMS; the full product
    // then gives the longest result, up to degree 2*MAX_TERMS-2.
    task automatic test_load_overflow();
        load_poly(pau_pkg::OP_LOAD_A, $urandom_range(MAX_TERMS + 1, MAX_TERMS + 3), 1'b0);
        load_poly(pau_pkg::OP_LOAD_B, MAX_TERMS, 1'b0);
        run_cmd(pau_pkg::FN_MUL, 32'd0);
        run_cmd(pau_pkg::FN_DERIV, 32'd0);
        run_cmd(pau_pkg::FN_EVAL, rand_value());
    endtask

    // Random sessions: usually reload one or both operands (sometimes mixed,
    // sometimes B as a copy of A so that subtraction cancels), then run a few
    // commands, with the odd ignored word thrown in.
    task automatic test_random_sequences(input int count);
        int         start;
        int         n;
        logic [2:0] f;

        start = words_sent;
        while (words_sent - start < count)
        begin
            if ($urandom_range(0, 3) != 0)
                load_poly(pau_pkg::OP_LOAD_A, pick_length(), $urandom_range(0, 3) == 0);
            if (len_a > 0 && $urandom_range(0, 5) == 0)
            begin
                n = len_a;
                for (int i = 0; i < n; i++)
                    load_coeff(pau_pkg::OP_LOAD_B, poly_a[i], i == n - 1);
            end
            else if ($urandom_range(0, 3) != 0)
                load_poly(pau_pkg::OP_LOAD_B, pick_length(), $urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 9) == 0)
                    send_word(OP_UNUSED, $urandom, 1'($urandom), 3'($urandom), $urandom);
                case ($urandom_range(0, 5))
                    0:       f = pau_pkg::FN_ADD;
                    1:       f = pau_pkg::FN_SUB;
                    2:       f = pau_pkg::FN_MUL;
                    3:       f = pau_pkg::FN_DERIV;
                    4:       f = pau_pkg::FN_EVAL;
                    default: f = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
                endcase
                run_cmd(f, rand_value());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        mismatches  = 0;
        words_sent  = 0;
        bursts_on   = 1'b0;
        len_a       = 0;
        len_b       = 0;
        load_pos    = 0;
        rst_n       <= 1'b0;
        cmd_valid   <= 1'b0;
        op          <= pau_pkg::OP_LOAD_A;
        coeff       <= '0;
        final_coeff <= 1'b0;
        func        <= pau_pkg::FN_ADD;
        point       <= '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        bursts_on = 1'b1;
        test_empty_operands();
        test_extreme_values();
        test_mixed_load();
        // Let the block drain completely before the long product.
        wait_drained();
        test_load_overflow();
        wait_drained();
        test_random_sequences(140);
        // The last stretch runs with no idling on either side.
        bursts_on = 1'b0;
        test_random_sequences(60);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[polynomial_arithmetic_unit] OK");
        else
            $display("[polynomial_arithmetic_unit] ERROR");
        $finish;
    end

endmodule
